/* design/rpid_pkg.sv */
package rpid_pkg;

    localparam int INTEGRAL_BITS_DEFAULT = 48;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 32;
    localparam int POS_W                 = 32;
    localparam int GAIN_W                = 32;
    localparam int STEP_W                = 31;
    localparam int LIMIT_W               = 24;
    localparam int CMD_W                 = 25;
    localparam int FRAC_SHIFT            = 24;
    localparam int TERM_W                = 42;
    localparam longint TERM_LIMIT        = 64'sd1 <<< 40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TARGET      = 3'd3,
        REG_RAMP_STEP   = 3'd4,
        REG_DRIVE_LIMIT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i_times_dt;
        logic signed [GAIN_W-1:0] gain_d_over_dt;
        logic signed [POS_W-1:0]  target_position;
        logic [STEP_W-1:0]        ramp_step;
        logic [LIMIT_W-1:0]       drive_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:          32'sd8388608,
        gain_i_times_dt: 32'sd168,
        gain_d_over_dt:  32'sd83886080,
        target_position: 32'sd0,
        ramp_step:       31'd16384,
        drive_limit:     24'd1572864
    };

endpackage

/* design/rpid_meas_if.sv */
interface rpid_meas_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [rpid_pkg::POS_W-1:0]        measured_position;

    modport source (output valid, output measured_position, input ready);
    modport sink   (input valid, input measured_position, output ready);

endinterface

/* design/rpid_cmd_if.sv */
interface rpid_cmd_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [rpid_pkg::CMD_W-1:0]        drive_command;
    logic signed [rpid_pkg::POS_W-1:0]        desired_position;
    logic                                     drive_clamped;

    modport source (output valid, output drive_command, output desired_position,
                    output drive_clamped, input ready);
    modport sink   (input valid, input drive_command, input desired_position,
                    input drive_clamped, output ready);

endinterface

/* design/rpid_ramp.sv */
// Setpoint ramp: moves toward the target by at most one step, stops on it.
module rpid_ramp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpid_pkg::cfg_t                    cfg,
    input  logic                              advance,
    output logic signed [rpid_pkg::POS_W-1:0] setpoint
);

    localparam int PW = rpid_pkg::POS_W;

    logic signed [PW-1:0] setpoint_reg;
    logic signed [PW-1:0] setpoint_next;
    logic signed [PW:0]   diff;
    logic [PW:0]          span;
    logic [PW:0]          step_ext;

    always_comb
    begin
        diff     = {cfg.target_position[PW-1], cfg.target_position}
                 - {setpoint_reg[PW-1], setpoint_reg};
        span     = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
        step_ext = {2'b00, cfg.ramp_step};
        if (diff == '0)
        begin
            setpoint_next = setpoint_reg;
        end
        else if (span > step_ext)
        begin
            if (diff[PW])
                setpoint_next = setpoint_reg - PW'(cfg.ramp_step);
            else
                setpoint_next = setpoint_reg + PW'(cfg.ramp_step);
        end
        else
        begin
            setpoint_next = cfg.target_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setpoint_reg <= '0;
        else if (advance)
            setpoint_reg <= setpoint_next;
    end

    assign setpoint = setpoint_next;

endmodule

/* design/ramped_pid_position_controller.sv */
// Channel      Role     Payload
// measurement  sink     measured_position (s32 Q16.16)
// command      source   drive_command (s25 Q16.16), desired_position (s32), drive_clamped
//
// Six-stage pipeline: ramp, error, integral/derivative, multiply, term combine,
// sum and clamp into the output register. One tick per cycle unless the output stalls.
// Each stage holds while its successor is full and stalled, so empty stages keep
// taking transfers. rst_n clears valids and controller state, reloads config defaults.
module ramped_pid_position_controller
#(
    parameter int INTEGRAL_BITS = rpid_pkg::INTEGRAL_BITS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rpid_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rpid_pkg::CFG_DATA_W-1:0]        cfg_data,
    rpid_meas_if.sink                              measurement,
    rpid_cmd_if.source                             command
);

    localparam int IB     = INTEGRAL_BITS;
    localparam int PW     = rpid_pkg::POS_W;
    localparam int TW     = rpid_pkg::TERM_W;
    localparam int FS     = rpid_pkg::FRAC_SHIFT;
    localparam int HI_W   = IB - 32;
    localparam int IRAW_W = IB + 9;
    localparam int NSTAGE = 6;

    localparam logic signed [IRAW_W-1:0] I_MAX = IRAW_W'(rpid_pkg::TERM_LIMIT);
    localparam logic signed [IRAW_W-1:0] I_MIN = -I_MAX;
    localparam logic signed [IB-1:0]     SUM_MAX = {1'b0, {(IB-1){1'b1}}};
    localparam logic signed [IB-1:0]     SUM_MIN = {1'b1, {(IB-1){1'b0}}};

    // configuration
    rpid_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= rpid_pkg::CFG_RESET;
        else if (cfg_we)
        begin
            unique case (rpid_pkg::cfg_index_t'(cfg_index))
                rpid_pkg::REG_GAIN_P:      cfg_reg.gain_p          <= $signed(cfg_data);
                rpid_pkg::REG_GAIN_I:      cfg_reg.gain_i_times_dt <= $signed(cfg_data);
                rpid_pkg::REG_GAIN_D:      cfg_reg.gain_d_over_dt  <= $signed(cfg_data);
                rpid_pkg::REG_TARGET:      cfg_reg.target_position <= $signed(cfg_data);
                rpid_pkg::REG_RAMP_STEP:
                    cfg_reg.ramp_step   <= cfg_data[rpid_pkg::STEP_W-1:0];
                rpid_pkg::REG_DRIVE_LIMIT:
                    cfg_reg.drive_limit <= cfg_data[rpid_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NSTAGE-1:0] stv_reg;
    logic [NSTAGE-1:0] stv_next;
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] inc;
    logic [NSTAGE-1:0] load;

    always_comb
    begin
        inc = {stv_reg[NSTAGE-2:0], measurement.valid};
        en[NSTAGE-1] = !stv_reg[NSTAGE-1] || command.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            en[k] = !stv_reg[k] || en[k+1];
        load     = en & inc;
        stv_next = (en & inc) | (~en & stv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stv_reg <= '0;
        else
            stv_reg <= stv_next;
    end

    assign measurement.ready = en[0];
    assign command.valid     = stv_reg[NSTAGE-1];

    // stage 1: ramp
    logic signed [PW-1:0] sp_new;

    rpid_ramp u_ramp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .advance  (load[0]),
        .setpoint (sp_new)
    );

    logic signed [PW-1:0] s1_sp_reg, s1_meas_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_sp_reg   <= sp_new;
            s1_meas_reg <= measurement.measured_position;
        end
    end

    // stage 2: error
    logic signed [PW:0]   err_wide;
    logic signed [PW-1:0] err_sat;
    logic signed [PW-1:0] s2_sp_reg, s2_err_reg;

    always_comb
    begin
        err_wide = {s1_sp_reg[PW-1], s1_sp_reg} - {s1_meas_reg[PW-1], s1_meas_reg};
        if (err_wide[PW] != err_wide[PW-1])
            err_sat = err_wide[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        else
            err_sat = err_wide[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_sp_reg  <= s1_sp_reg;
            s2_err_reg <= err_sat;
        end
    end

    // stage 3: integral and derivative
    logic signed [IB-1:0] error_sum_reg;
    logic signed [IB-1:0] error_sum_next;
    logic signed [IB:0]   sum_wide;
    logic signed [PW-1:0] last_error_reg;
    logic signed [PW:0]   dd;

    always_comb
    begin
        sum_wide = (IB+1)'(error_sum_reg) + (IB+1)'(s2_err_reg);
        if (sum_wide[IB] != sum_wide[IB-1])
            error_sum_next = sum_wide[IB] ? SUM_MIN : SUM_MAX;
        else
            error_sum_next = sum_wide[IB-1:0];
        dd = {s2_err_reg[PW-1], s2_err_reg} - {last_error_reg[PW-1], last_error_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (load[2])
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= s2_err_reg;
        end
    end

    logic signed [PW-1:0] s3_sp_reg, s3_err_reg;
    logic signed [PW:0]   s3_dd_reg;
    logic signed [IB-1:0] s3_sum_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_sp_reg  <= s2_sp_reg;
            s3_err_reg <= s2_err_reg;
            s3_dd_reg  <= dd;
            s3_sum_reg <= error_sum_next;
        end
    end

    // stage 4: products; the integral is split at bit 32 into two partials
    logic signed [HI_W-1:0] sum_hi;
    logic signed [63:0]     pp_w;
    logic signed [64:0]     dp_w;
    logic signed [64:0]     il_w;
    logic signed [IB-1:0]   ih_w;

    always_comb
    begin
        sum_hi = s3_sum_reg[IB-1:32];
        pp_w   = 64'(cfg_reg.gain_p) * 64'(s3_err_reg);
        dp_w   = 65'(cfg_reg.gain_d_over_dt) * 65'(s3_dd_reg);
        il_w   = 65'(cfg_reg.gain_i_times_dt) * $signed({33'd0, s3_sum_reg[31:0]});
        ih_w   = (IB)'(cfg_reg.gain_i_times_dt) * (IB)'(sum_hi);
    end

    logic signed [PW-1:0] s4_sp_reg;
    logic signed [63:0]   s4_pp_reg;
    logic signed [64:0]   s4_dp_reg;
    logic signed [64:0]   s4_il_reg;
    logic signed [IB-1:0] s4_ih_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_sp_reg <= s3_sp_reg;
            s4_pp_reg <= pp_w;
            s4_dp_reg <= dp_w;
            s4_il_reg <= il_w;
            s4_ih_reg <= ih_w;
        end
    end

    // stage 5: floor shift, integral term saturation, P + D
    logic signed [IRAW_W-1:0] i_raw;
    logic signed [TW-1:0]     i_term;
    logic signed [TW-1:0]     pd_sum;

    always_comb
    begin
        i_raw = IRAW_W'($signed({s4_ih_reg, 8'h00}))
              + IRAW_W'($signed(s4_il_reg[64:FS]));
        if (i_raw > I_MAX)
            i_term = TW'(I_MAX);
        else if (i_raw < I_MIN)
            i_term = TW'(I_MIN);
        else
            i_term = TW'(i_raw);
        pd_sum = TW'($signed(s4_pp_reg[63:FS])) + TW'($signed(s4_dp_reg[64:FS]));
    end

    logic signed [PW-1:0] s5_sp_reg;
    logic signed [TW-1:0] s5_i_reg, s5_pd_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_sp_reg <= s4_sp_reg;
            s5_i_reg  <= i_term;
            s5_pd_reg <= pd_sum;
        end
    end

    // stage 6: total and clamp
    logic signed [TW-1:0]                  total;
    logic signed [TW-1:0]                  lim;
    logic signed [rpid_pkg::CMD_W-1:0]     cmd;
    logic                                  clamped;

    always_comb
    begin
        total = s5_pd_reg + s5_i_reg;
        lim   = $signed({(TW-rpid_pkg::LIMIT_W)'(0), cfg_reg.drive_limit});
        if (total > lim)
        begin
            cmd     = rpid_pkg::CMD_W'(lim);
            clamped = 1'b1;
        end
        else if (total < -lim)
        begin
            cmd     = rpid_pkg::CMD_W'(-lim);
            clamped = 1'b1;
        end
        else
        begin
            cmd     = rpid_pkg::CMD_W'(total);
            clamped = 1'b0;
        end
    end

    logic signed [rpid_pkg::CMD_W-1:0] out_cmd_reg;
    logic signed [PW-1:0]              out_sp_reg;
    logic                              out_clamped_reg;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            out_cmd_reg     <= cmd;
            out_sp_reg      <= s5_sp_reg;
            out_clamped_reg <= clamped;
        end
    end

    assign command.drive_command    = out_cmd_reg;
    assign command.desired_position = out_sp_reg;
    assign command.drive_clamped    = out_clamped_reg;

endmodule
